### rtl/pcf_pkg.sv
`default_nettype none
package pcf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int CLAMP_LO  = -((3 * ONE) / 10);
    localparam int CLAMP_HI  = 3 * ONE;

    localparam logic [20:0] STIFF_RST = 21'(3 * ONE);
    localparam logic [16:0] DAMP_RST  = 17'(ONE / 5);
    localparam logic [23:0] SCALE_RST = 24'(32 * ONE);

    localparam int SQRT_BITS = 18;
    localparam int SQ_STAGES = SQRT_BITS / 2;
    localparam int VQ_W      = 36;
    localparam int NQ_W      = 18;
    localparam int RQ_W      = FRAC_BITS;
    localparam int FQ_W      = 38;
    localparam int D1_STAGES = VQ_W / 2;
    localparam int D2_STAGES = FQ_W / 2;
    localparam int NST       = 2 + SQ_STAGES + D1_STAGES + 3 + D2_STAGES + 4;

    localparam logic signed [39:0] F_LIM  = 40'sd1 <<< 38;
    localparam logic signed [63:0] FS_LIM = 64'sd1 <<< 40;

    typedef enum logic [1:0] {
        CFG_STIFFNESS = 2'd0,
        CFG_DAMPING   = 2'd1,
        CFG_SCALE     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic               small_x;
        logic               small_y;
        logic [36:0]        sqx;
        logic [36:0]        sqy;
        logic [35:0]        sr2;
        logic signed [51:0] pvx;
        logic signed [51:0] pvy;
        logic signed [36:0] nxp;
        logic signed [36:0] nyp;
        logic [17:0]        sr;
    } t_s1;

    typedef struct packed {
        logic        contact;
        logic [35:0] rad;
        logic [35:0] root;
        logic        vneg;
        logic [51:0] vmag;
        logic        xneg;
        logic [35:0] xmag;
        logic        yneg;
        logic [35:0] ymag;
        logic [17:0] sr;
    } t_root;

    typedef struct packed {
        logic               contact;
        logic [17:0]        dlen;
        logic [17:0]        sr;
        logic               vneg;
        logic [51:0]        vrem;
        logic [VQ_W-1:0]    vq;
        logic [17+RQ_W:0]   rrem;
        logic [RQ_W-1:0]    rq;
        logic               xneg;
        logic [35:0]        xrem;
        logic [NQ_W-1:0]    xq;
        logic               yneg;
        logic [35:0]        yrem;
        logic [NQ_W-1:0]    yq;
    } t_div1;

    typedef struct packed {
        logic               contact;
        logic signed [54:0] cp;
        logic signed [22:0] k;
        logic [RQ_W-1:0]    r;
        logic signed [18:0] nx;
        logic signed [18:0] ny;
    } t_mid;

    typedef struct packed {
        logic               contact;
        logic               nneg;
        logic               nzero;
        logic               dneg;
        logic               dzero;
        logic [37:0]        frem;
        logic [21:0]        dmag;
        logic [FQ_W-1:0]    fq;
        logic signed [18:0] nx;
        logic signed [18:0] ny;
    } t_div2;

    typedef struct packed {
        logic               contact;
        logic signed [63:0] fsp;
        logic signed [41:0] fs;
        logic signed [60:0] px;
        logic signed [60:0] py;
        logic signed [18:0] nx;
        logic signed [18:0] ny;
    } t_fin;

    typedef struct packed {
        logic               contact;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
    } t_res;

endpackage
`default_nettype wire

### rtl/pairwise_contact_force_unit.sv
`default_nettype none
// Contact force kernel for pairs of disc particles in signed Q16.16. One candidate pair can
// be transferred in every clock cycle in which o_ready is high, and each pair gives exactly
// one result, in order. The datapath holds a nine-stage square root and two restoring
// dividers that retire two quotient bits per stage (18 and 19 stages). A result waiting at
// the output does not block the input while the last pipeline stage is empty.
// Configuration registers are written through a simple write port and must only be
// changed while no pair is in flight.
module pairwise_contact_force_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [1:0]          i_cfg_idx,
    input  wire [23:0]         i_cfg_data,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire signed [31:0]  i_delta_x,
    input  wire signed [31:0]  i_delta_y,
    input  wire [17:0]         i_sum_radius,
    input  wire signed [31:0]  i_vel_a_x,
    input  wire signed [31:0]  i_vel_a_y,
    input  wire signed [31:0]  i_vel_b_x,
    input  wire signed [31:0]  i_vel_b_y,
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [31:0] o_force_x,
    output logic signed [31:0] o_force_y,
    output logic               o_contact
);
    import pcf_pkg::*;

    logic [20:0]    r_sb;
    logic [16:0]    r_dg;
    logic [23:0]    r_fsc;
    logic [NST-1:0] r_vld;
    logic           r_ov;
    logic           pipe_adv;

    t_s1   r_s1, n_s1;
    t_root r_root0, n_root0;
    t_root r_sqrt [0:SQ_STAGES-1];
    t_div1 n_d1_init;
    t_div1 r_d1 [0:D1_STAGES-1];
    t_mid  r_m1, n_m1, r_m2, n_m2;
    t_div2 r_m3, n_m3;
    t_div2 r_d2 [0:D2_STAGES-1];
    t_fin  r_f1, n_f1, r_f2, n_f2, r_f3, n_f3;
    t_res  r_f4, n_f4, r_out;

    logic signed [18:0] n_dx;
    logic signed [18:0] n_dy;
    logic signed [32:0] n_rvx;
    logic signed [32:0] n_rvy;

    assign pipe_adv = !r_vld[NST-1] || !r_ov || i_ready;
    assign o_ready  = pipe_adv;
    assign o_valid  = r_ov;
    assign o_force_x = r_out.fx;
    assign o_force_y = r_out.fy;
    assign o_contact = r_out.contact;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb  <= STIFF_RST;
            r_dg  <= DAMP_RST;
            r_fsc <= SCALE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STIFFNESS: r_sb  <= i_cfg_data[20:0];
                CFG_DAMPING:   r_dg  <= i_cfg_data[16:0];
                CFG_SCALE:     r_fsc <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (pipe_adv) begin
                r_vld <= {r_vld[NST-2:0], i_valid & o_ready};
            end
            if (!r_ov || i_ready) begin
                r_ov <= r_vld[NST-1];
            end
        end
    end

    // Only the low 19 offset bits matter: a larger offset can never be in contact.
    assign n_dx  = i_delta_x[18:0];
    assign n_dy  = i_delta_y[18:0];
    assign n_rvx = 33'(i_vel_a_x) - 33'(i_vel_b_x);
    assign n_rvy = 33'(i_vel_a_y) - 33'(i_vel_b_y);

    always_comb begin
        n_s1.small_x = (i_delta_x[31:19] == {13{i_delta_x[18]}});
        n_s1.small_y = (i_delta_y[31:19] == {13{i_delta_y[18]}});
        n_s1.sqx     = 37'(38'(n_dx) * 38'(n_dx));
        n_s1.sqy     = 37'(38'(n_dy) * 38'(n_dy));
        n_s1.sr2     = 36'(i_sum_radius) * 36'(i_sum_radius);
        n_s1.pvx     = 52'(n_rvx) * 52'(n_dx);
        n_s1.pvy     = 52'(n_rvy) * 52'(n_dy);
        n_s1.nxp     = 37'(n_dx) * 37'($signed({1'b0, i_sum_radius}));
        n_s1.nyp     = 37'(n_dy) * 37'($signed({1'b0, i_sum_radius}));
        n_s1.sr      = i_sum_radius;
    end

    always_comb begin
        logic [37:0]        sq;
        logic signed [52:0] vnum;
        sq   = 38'(r_s1.sqx) + 38'(r_s1.sqy);
        vnum = 53'(r_s1.pvx) + 53'(r_s1.pvy);
        n_root0.contact = r_s1.small_x && r_s1.small_y && (sq != '0)
                          && (sq < 38'(r_s1.sr2));
        n_root0.rad  = sq[35:0];
        n_root0.root = '0;
        n_root0.vneg = vnum[52];
        n_root0.vmag = vnum[52] ? 52'(-vnum) : 52'(vnum);
        n_root0.xneg = r_s1.nxp[36];
        n_root0.xmag = r_s1.nxp[36] ? 36'(-r_s1.nxp) : 36'(r_s1.nxp);
        n_root0.yneg = r_s1.nyp[36];
        n_root0.ymag = r_s1.nyp[36] ? 36'(-r_s1.nyp) : 36'(r_s1.nyp);
        n_root0.sr   = r_s1.sr;
    end

    always_ff @(posedge i_clk) begin
        if (pipe_adv) begin
            r_s1    <= n_s1;
            r_root0 <= n_root0;
        end
    end

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sqrt
        t_root n_src;
        t_root n_q;
        if (s == 0) begin : g_src
            always_comb n_src = r_root0;
        end else begin : g_src
            always_comb n_src = r_sqrt[s-1];
        end
        always_comb begin
            logic [35:0] bitv;
            logic [35:0] trial;
            n_q = n_src;
            for (int t = 0; t < 2; t++) begin
                bitv  = 36'(1) << (2 * (SQRT_BITS - 1 - (2 * s + t)));
                trial = n_q.root + bitv;
                if (n_q.rad >= trial) begin
                    n_q.rad  = n_q.rad - trial;
                    n_q.root = (n_q.root >> 1) + bitv;
                end else begin
                    n_q.root = n_q.root >> 1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (pipe_adv) begin
                r_sqrt[s] <= n_q;
            end
        end
    end

    always_comb begin
        n_d1_init.contact = r_sqrt[SQ_STAGES-1].contact;
        n_d1_init.dlen    = r_sqrt[SQ_STAGES-1].root[17:0];
        n_d1_init.sr      = r_sqrt[SQ_STAGES-1].sr;
        n_d1_init.vneg    = r_sqrt[SQ_STAGES-1].vneg;
        n_d1_init.vrem    = r_sqrt[SQ_STAGES-1].vmag;
        n_d1_init.vq      = '0;
        n_d1_init.rrem    = {r_sqrt[SQ_STAGES-1].root[17:0], {RQ_W{1'b0}}};
        n_d1_init.rq      = '0;
        n_d1_init.xneg    = r_sqrt[SQ_STAGES-1].xneg;
        n_d1_init.xrem    = r_sqrt[SQ_STAGES-1].xmag;
        n_d1_init.xq      = '0;
        n_d1_init.yneg    = r_sqrt[SQ_STAGES-1].yneg;
        n_d1_init.yrem    = r_sqrt[SQ_STAGES-1].ymag;
        n_d1_init.yq      = '0;
    end

    for (genvar s = 0; s < D1_STAGES; s++) begin : g_div1
        t_div1 n_src;
        t_div1 n_d;
        if (s == 0) begin : g_src
            always_comb n_src = n_d1_init;
        end else begin : g_src
            always_comb n_src = r_d1[s-1];
        end
        always_comb begin
            logic [53:0]      vsub;
            logic [18+RQ_W:0] rsub;
            logic [36:0]      xsub;
            logic [36:0]      ysub;
            int               g;
            n_d  = n_src;
            vsub = '0;
            rsub = '0;
            xsub = '0;
            ysub = '0;
            for (int t = 0; t < 2; t++) begin
                g = 2 * s + t;
                if (g < VQ_W) begin
                    vsub = 54'(n_d.dlen) << (VQ_W - 1 - g);
                    if (54'(n_d.vrem) >= vsub) begin
                        n_d.vrem = n_d.vrem - vsub[51:0];
                        n_d.vq   = n_d.vq | (VQ_W'(1) << (VQ_W - 1 - g));
                    end
                end
                if (g < RQ_W) begin
                    rsub = (19 + RQ_W)'(n_d.sr) << (RQ_W - 1 - g);
                    if ((19 + RQ_W)'(n_d.rrem) >= rsub) begin
                        n_d.rrem = n_d.rrem - rsub[17+RQ_W:0];
                        n_d.rq   = n_d.rq | (RQ_W'(1) << (RQ_W - 1 - g));
                    end
                end
                if (g < NQ_W) begin
                    xsub = 37'(n_d.dlen) << (NQ_W - 1 - g);
                    ysub = 37'(n_d.dlen) << (NQ_W - 1 - g);
                    if (37'(n_d.xrem) >= xsub) begin
                        n_d.xrem = n_d.xrem - xsub[35:0];
                        n_d.xq   = n_d.xq | (NQ_W'(1) << (NQ_W - 1 - g));
                    end
                    if (37'(n_d.yrem) >= ysub) begin
                        n_d.yrem = n_d.yrem - ysub[35:0];
                        n_d.yq   = n_d.yq | (NQ_W'(1) << (NQ_W - 1 - g));
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (pipe_adv) begin
                r_d1[s] <= n_d;
            end
        end
    end

    always_comb begin
        logic signed [36:0] vapp;
        vapp = $signed(37'(r_d1[D1_STAGES-1].vq));
        if (r_d1[D1_STAGES-1].vneg) begin
            vapp = -vapp;
        end
        n_m1.contact = r_d1[D1_STAGES-1].contact;
        n_m1.cp      = 55'(vapp) * 55'($signed({1'b0, r_dg}));
        n_m1.k       = '0;
        n_m1.r       = r_d1[D1_STAGES-1].rq;
        n_m1.nx      = $signed(19'(r_d1[D1_STAGES-1].xq));
        n_m1.ny      = $signed(19'(r_d1[D1_STAGES-1].yq));
        if (r_d1[D1_STAGES-1].xneg) begin
            n_m1.nx = -n_m1.nx;
        end
        if (r_d1[D1_STAGES-1].yneg) begin
            n_m1.ny = -n_m1.ny;
        end
    end

    always_comb begin
        logic signed [54:0] cs;
        logic signed [18:0] c;
        cs = r_m1.cp >>> FRAC_BITS;
        if (cs < 55'(CLAMP_LO)) begin
            c = 19'(CLAMP_LO);
        end else if (cs > 55'(CLAMP_HI)) begin
            c = 19'(CLAMP_HI);
        end else begin
            c = cs[18:0];
        end
        n_m2   = r_m1;
        n_m2.k = -$signed({2'b0, r_sb}) - 23'(c);
    end

    always_comb begin
        logic signed [17:0] omr;
        logic signed [40:0] num;
        logic signed [23:0] den;
        omr = $signed(18'(ONE) - {{(18 - RQ_W){1'b0}}, r_m2.r});
        num = 41'(r_m2.k) * 41'(omr);
        den = 24'(r_m2.k) + $signed({{(24 - RQ_W){1'b0}}, r_m2.r});
        n_m3.contact = r_m2.contact;
        n_m3.nneg    = num[40];
        n_m3.nzero   = (num == '0);
        n_m3.dneg    = den[23];
        n_m3.dzero   = (den == '0);
        n_m3.frem    = num[40] ? 38'(-num) : 38'(num);
        n_m3.dmag    = den[23] ? 22'(-den) : 22'(den);
        n_m3.fq      = '0;
        n_m3.nx      = r_m2.nx;
        n_m3.ny      = r_m2.ny;
    end

    always_ff @(posedge i_clk) begin
        if (pipe_adv) begin
            r_m1 <= n_m1;
            r_m2 <= n_m2;
            r_m3 <= n_m3;
        end
    end

    for (genvar s = 0; s < D2_STAGES; s++) begin : g_div2
        t_div2 n_src;
        t_div2 n_d;
        if (s == 0) begin : g_src
            always_comb n_src = r_m3;
        end else begin : g_src
            always_comb n_src = r_d2[s-1];
        end
        always_comb begin
            logic [59:0] fsub;
            int          g;
            n_d  = n_src;
            fsub = '0;
            for (int t = 0; t < 2; t++) begin
                g = 2 * s + t;
                if (g < FQ_W) begin
                    fsub = 60'(n_d.dmag) << (FQ_W - 1 - g);
                    if (60'(n_d.frem) >= fsub) begin
                        n_d.frem = n_d.frem - fsub[37:0];
                        n_d.fq   = n_d.fq | (FQ_W'(1) << (FQ_W - 1 - g));
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (pipe_adv) begin
                r_d2[s] <= n_d;
            end
        end
    end

    // A zero denominator takes the limit in the direction of the numerator.
    always_comb begin
        logic signed [39:0] f;
        if (r_d2[D2_STAGES-1].dzero) begin
            if (r_d2[D2_STAGES-1].nneg) begin
                f = -F_LIM;
            end else if (r_d2[D2_STAGES-1].nzero) begin
                f = '0;
            end else begin
                f = F_LIM;
            end
        end else begin
            f = $signed(40'(r_d2[D2_STAGES-1].fq));
            if (r_d2[D2_STAGES-1].nneg ^ r_d2[D2_STAGES-1].dneg) begin
                f = -f;
            end
        end
        n_f1.contact = r_d2[D2_STAGES-1].contact;
        n_f1.fsp     = 64'(f) * 64'($signed({1'b0, r_fsc}));
        n_f1.fs      = '0;
        n_f1.px      = '0;
        n_f1.py      = '0;
        n_f1.nx      = r_d2[D2_STAGES-1].nx;
        n_f1.ny      = r_d2[D2_STAGES-1].ny;
    end

    always_comb begin
        logic signed [63:0] sh;
        sh   = r_f1.fsp >>> FRAC_BITS;
        n_f2 = r_f1;
        if (sh > FS_LIM) begin
            n_f2.fs = 42'(FS_LIM);
        end else if (sh < -FS_LIM) begin
            n_f2.fs = 42'(-FS_LIM);
        end else begin
            n_f2.fs = sh[41:0];
        end
    end

    always_comb begin
        n_f3    = r_f2;
        n_f3.px = 61'(r_f2.nx) * 61'(r_f2.fs);
        n_f3.py = 61'(r_f2.ny) * 61'(r_f2.fs);
    end

    always_comb begin
        logic signed [60:0] shx;
        logic signed [60:0] shy;
        shx = r_f3.px >>> FRAC_BITS;
        shy = r_f3.py >>> FRAC_BITS;
        n_f4.contact = r_f3.contact;
        if (shx > 61'sd2147483647) begin
            n_f4.fx = 32'sh7FFF_FFFF;
        end else if (shx < -61'sd2147483648) begin
            n_f4.fx = 32'sh8000_0000;
        end else begin
            n_f4.fx = shx[31:0];
        end
        if (shy > 61'sd2147483647) begin
            n_f4.fy = 32'sh7FFF_FFFF;
        end else if (shy < -61'sd2147483648) begin
            n_f4.fy = 32'sh8000_0000;
        end else begin
            n_f4.fy = shy[31:0];
        end
        if (!r_f3.contact) begin
            n_f4.fx = '0;
            n_f4.fy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_adv) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
            r_f3 <= n_f3;
            r_f4 <= n_f4;
        end
        if (!r_ov || i_ready) begin
            r_out <= r_f4;
        end
    end

    a_no_contact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_contact) |-> (o_force_x == '0 && o_force_y == '0))
        else $error("force is nonzero without contact");

    a_transfer_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted pair did not enter the pipeline");

    a_last_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-1] && !o_ready) |=> (r_vld[NST-1] && $stable(r_f4)))
        else $error("stalled last stage lost its result");

endmodule
`default_nettype wire
